// ===== rtl/eco_pkg.sv =====
// Shared constants for the envelope cutoff controller.
package eco_pkg;

  localparam int ACC_W = 57;
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 17;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int SWEEP_SHIFT = 35;
  localparam int ENV_W = 24;
  localparam int CUT_W = 20;

  localparam logic [CUT_W-1:0] CUTOFF_FLOOR = 20'd640;
  localparam logic [CUT_W:0] UPDATE_THRESHOLD = 21'd8;
  localparam logic [ENV_W-1:0] ENV_FULL_SCALE = 24'h800000;

  localparam logic [2:0] REG_ATTACK = 3'd0;
  localparam logic [2:0] REG_RELEASE = 3'd1;
  localparam logic [2:0] REG_BASE = 3'd2;
  localparam logic [2:0] REG_RANGE = 3'd3;
  localparam logic [2:0] REG_SENS = 3'd4;
  localparam logic [2:0] REG_CUTMAX = 3'd5;

  localparam logic [15:0] ATTACK_RESET = 16'd65399;
  localparam logic [15:0] RELEASE_RESET = 16'd65522;
  localparam logic [14:0] BASE_RESET = 15'd6400;
  localparam logic [16:0] RANGE_RESET = 17'd32000;
  localparam logic [15:0] SENS_RESET = 16'd4096;
  localparam logic [19:0] CUTMAX_RESET = 20'd345600;

endpackage

// ===== rtl/envelope_cutoff_controller.sv =====
// Envelope follower and cutoff controller built around one shared 24x17 multiplier.
// Results are offered in ST_OUT after ST_M0 and ST_M1, and on a control sample also after
// ST_M2, ST_M3, ST_M4, ST_RND, ST_SUM, ST_CLAMP and ST_CMP. A new sample is taken only in
// ST_IDLE, after out_stall frees ST_OUT; the sequencer shares one multiplier and accumulator.
// Reset (synchronous) loads the register defaults and clears envelope, cutoff and phase.
module envelope_cutoff_controller
  import eco_pkg::*;
#(
  parameter int CONTROL_INTERVAL = 32,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           block_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic        [ENV_W-1:0]        envelope,
  output logic        [CUT_W-1:0]        cutoff,
  output logic                           cutoff_update,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic        [4:0]              paddr,
  input  logic        [31:0]             pwdata,
  output logic        [31:0]             prdata,
  output logic                           pready
);

  localparam int PH_W = (CONTROL_INTERVAL > 1) ? $clog2(CONTROL_INTERVAL) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(CONTROL_INTERVAL - 1);
  localparam int RS = (SAMPLE_WIDTH > 24) ? SAMPLE_WIDTH - 24 : 0;
  localparam int LS = (SAMPLE_WIDTH < 24) ? 24 - SAMPLE_WIDTH : 0;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M0 = 4'd1;
  localparam logic [3:0] ST_M1 = 4'd2;
  localparam logic [3:0] ST_M2 = 4'd3;
  localparam logic [3:0] ST_M3 = 4'd4;
  localparam logic [3:0] ST_M4 = 4'd5;
  localparam logic [3:0] ST_RND = 4'd6;
  localparam logic [3:0] ST_SUM = 4'd7;
  localparam logic [3:0] ST_CLAMP = 4'd8;
  localparam logic [3:0] ST_CMP = 4'd9;
  localparam logic [3:0] ST_OUT = 4'd10;

  logic [15:0] attack_coeff;
  logic [15:0] release_coeff;
  logic [14:0] base_cutoff;
  logic [16:0] sweep_range;
  logic [15:0] sensitivity;
  logic [19:0] cutoff_max;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [PH_W-1:0] phase;
  logic [PH_W-1:0] phase_eff;
  logic ctrl;
  logic [ENV_W-1:0] rect;
  logic [ENV_W-1:0] rect_in;
  logic [15:0] coef;
  logic [ENV_W-1:0] env;
  logic [CUT_W-1:0] applied;
  logic update;
  logic [PROD_W-1:0] prod1;
  logic [ACC_W-1:0] acc;
  logic signed [23:0] cut;

  logic [SAMPLE_WIDTH-1:0] mag;
  logic [55:0] mag_ext;
  logic [16:0] smag;
  logic sens_neg;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0] add_x;
  logic [ACC_W-1:0] add_y;
  logic [ACC_W-1:0] sum;
  logic [21:0] rmag;
  logic signed [24:0] diff;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[4:2])
      REG_ATTACK: prdata = {16'd0, attack_coeff};
      REG_RELEASE: prdata = {16'd0, release_coeff};
      REG_BASE: prdata = {17'd0, base_cutoff};
      REG_RANGE: prdata = {15'd0, sweep_range};
      REG_SENS: prdata = {16'd0, sensitivity};
      REG_CUTMAX: prdata = {12'd0, cutoff_max};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coeff <= ATTACK_RESET;
      release_coeff <= RELEASE_RESET;
      base_cutoff <= BASE_RESET;
      sweep_range <= RANGE_RESET;
      sensitivity <= SENS_RESET;
      cutoff_max <= CUTMAX_RESET;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_ATTACK: attack_coeff <= pwdata[15:0];
        REG_RELEASE: release_coeff <= pwdata[15:0];
        REG_BASE: base_cutoff <= pwdata[14:0];
        REG_RANGE: sweep_range <= pwdata[16:0];
        REG_SENS: sensitivity <= pwdata[15:0];
        REG_CUTMAX: cutoff_max <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign envelope = env;
  assign cutoff = applied;
  assign cutoff_update = update;

  // The magnitude of the most negative sample wraps to the sign bit, which is full scale.
  assign mag = sample[SAMPLE_WIDTH-1] ? (~sample + 1'b1) : sample;
  assign mag_ext = 56'(mag);
  assign rect_in = 24'((mag_ext >> RS) << LS);
  assign phase_eff = block_start ? '0 : phase;

  assign sens_neg = sensitivity[15];
  assign smag = sens_neg ? (17'd0 - {sensitivity[15], sensitivity}) : {1'b0, sensitivity};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_M0: begin
        mul_a = rect;
        mul_b = 17'h10000 - {1'b0, coef};
      end
      ST_M1: begin
        mul_a = env;
        mul_b = {1'b0, coef};
      end
      ST_M2: begin
        mul_a = env;
        mul_b = sweep_range;
      end
      ST_M3: begin
        mul_a = prod1[23:0];
        mul_b = smag;
      end
      ST_M4: begin
        mul_a = {7'd0, prod1[PROD_W-1:24]};
        mul_b = smag;
      end
      default: ;
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    add_x = '0;
    add_y = ACC_W'(prod);
    case (state)
      ST_M0: add_x = ACC_W'(32768);
      ST_M1: add_x = acc;
      ST_M4: begin
        add_x = acc;
        add_y = ACC_W'(prod) << 24;
      end
      ST_RND: begin
        add_x = acc;
        add_y = ACC_W'(1) << (SWEEP_SHIFT - 1);
      end
      default: ;
    endcase
  end

  assign sum = add_x + add_y;
  assign rmag = acc[SWEEP_SHIFT+21:SWEEP_SHIFT];
  assign diff = 25'(cut) - $signed({5'd0, applied});

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_M0;
      ST_M0: state_next = ST_M1;
      ST_M1: state_next = ctrl ? ST_M2 : ST_OUT;
      ST_M2: state_next = ST_M3;
      ST_M3: state_next = ST_M4;
      ST_M4: state_next = ST_RND;
      ST_RND: state_next = ST_SUM;
      ST_SUM: state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_CMP;
      ST_CMP: state_next = ST_OUT;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= '0;
      env <= '0;
      applied <= '0;
      update <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            phase <= (phase_eff == PH_LAST) ? '0 : phase_eff + 1'b1;
            update <= 1'b0;
          end
        end
        ST_M1: env <= sum[16+ENV_W-1:16];
        ST_CMP: begin
          if ((diff < 0 ? -diff : diff) > $signed({4'd0, UPDATE_THRESHOLD})) begin
            applied <= cut[CUT_W-1:0];
            update <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rect <= rect_in;
        coef <= (rect_in > env) ? attack_coeff : release_coeff;
        ctrl <= (phase_eff == '0);
      end
      ST_M0, ST_M1, ST_M3, ST_M4, ST_RND: acc <= sum;
      ST_M2: prod1 <= prod;
      ST_SUM: begin
        cut <= sens_neg ? ($signed({9'd0, base_cutoff}) - $signed({2'd0, rmag}))
                        : ($signed({9'd0, base_cutoff}) + $signed({2'd0, rmag}));
      end
      ST_CLAMP: begin
        if (cut > $signed({4'd0, cutoff_max})) begin
          cut <= (cutoff_max < CUTOFF_FLOOR) ? $signed({4'd0, CUTOFF_FLOOR})
                                             : $signed({4'd0, cutoff_max});
        end else if (cut < $signed({4'd0, CUTOFF_FLOOR})) begin
          cut <= $signed({4'd0, CUTOFF_FLOOR});
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_idle_no_out: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("output beat offered while accepting samples");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall && !out_valid)
    else $error("sequencer did not start after an accepted beat");

  a_env_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> envelope <= ENV_FULL_SCALE)
    else $error("envelope above full scale");

  a_update_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid && cutoff_update |-> cutoff >= CUTOFF_FLOOR)
    else $error("applied cutoff below floor");
`endif

endmodule
